FILE: rtl/core/dttf_pkg.sv
// Shared types, constants and helper functions of the decimal text to fixed point core.
package dttf_pkg;

    localparam int CHAR_W   = 8;
    localparam int AMOUNT_W = 54;
    localparam int ERR_W    = 3;
    localparam int CNT_W    = 4;
    localparam int SCALE_W  = 30;
    localparam int HALF_W   = AMOUNT_W / 2;

    localparam logic [CNT_W-1:0] CNT_SAT     = 4'd9;
    localparam logic [CNT_W-1:0] INT_DIGITS  = 4'd8;
    localparam logic [CNT_W-1:0] FRAC_DIGITS = 4'd8;

    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE         = 3'd0,
        ERR_BAD_CHAR     = 3'd1,
        ERR_SECOND_POINT = 3'd2,
        ERR_INT_DIGITS   = 3'd3,
        ERR_FRAC_DIGITS  = 3'd4,
        ERR_NO_DIGITS    = 3'd5
    } t_err;

    // One input word as held in the input register
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              has_character;
        logic              last;
    } t_char;

    // Finished string handed from the parser to the scaler
    typedef struct packed {
        t_err                err;
        logic [AMOUNT_W-1:0] value;
        logic [SCALE_W-1:0]  scale;
    } t_fin;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] n);
        return (n >= CNT_SAT) ? CNT_SAT : n + 4'd1;
    endfunction

    function automatic logic [SCALE_W-1:0] pow10(input logic [CNT_W-1:0] e);
        logic [SCALE_W-1:0] r;
        case (e)
            4'd0:    r = 30'd1;
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            4'd9:    r = 30'd1000000000;
            default: r = 30'd1;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/dttf_if.sv
// Stream interfaces of the core: character words in, amount words out.
interface dttf_in_if import dttf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              has_character;
    logic              last;

    modport source (output valid, output character, output has_character, output last,
                    input ready);
    modport sink   (input valid, input character, input has_character, input last,
                    output ready);
endinterface

interface dttf_out_if import dttf_pkg::*;;
    logic                valid;
    logic                ready;
    logic                valid_res;
    logic [AMOUNT_W-1:0] amount;
    logic [ERR_W-1:0]    error_code;

    modport source (output valid, output valid_res, output amount, output error_code,
                    input ready);
    modport sink   (input valid, input valid_res, input amount, input error_code,
                    output ready);
endinterface

FILE: rtl/core/decimal_text_to_fixed_point_core.sv
// Top level of the decimal text to fixed point core: input register, parser and scaler.
//
// The core takes an amount string one ASCII character per word and, on the word
// marked last, returns one result word: the value scaled by 10^FRACTION_DIGITS
// (10^8 by default) in 54 bits, a flag that the text was a legal amount, and an
// error code (bad character, second point, more than INTEGER_DIGITS integer or
// FRACTION_DIGITS fraction digits, or no digits at all; the first error found
// wins). Words without last give no result; a word with
// has_character low carries only the end mark, so an empty string is a single
// such word with last high. Digits and the point are folded in as they arrive,
// so the core takes one word every cycle with no gaps, also across string boundaries,
// unless a last word meets a full, stalled hand-off register. A result passes the
// input register, parser state and hand-off register, a register holding two 27 by 30
// bit partial products of the final power-of-ten scaling, and the output register that
// sums them. Each stage holds only while the one after it is full and stalled, so a
// result waiting on the output side does not stop characters from being taken. After
// a last word all string state is back at reset values.
module decimal_text_to_fixed_point_core import dttf_pkg::*; #(
    parameter logic [CNT_W-1:0] INTEGER_DIGITS  = INT_DIGITS,
    parameter logic [CNT_W-1:0] FRACTION_DIGITS = FRAC_DIGITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dttf_in_if.sink    i_in,
    dttf_out_if.source o_out
);

    logic  r_in_valid;
    t_char r_in;
    logic  take;
    logic  fin_valid;
    logic  fin_ready;
    t_fin  fin;

    // Input register: refill when empty or when the parser drains it this cycle
    assign i_in.ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.character     <= i_in.character;
            r_in.has_character <= i_in.has_character;
            r_in.last          <= i_in.last;
        end
    end

    // Parse: advance the string state, hand finished strings on
    dttf_parse #(
        .INTEGER_DIGITS  (INTEGER_DIGITS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_item      (r_in),
        .o_take      (take),
        .o_fin_valid (fin_valid),
        .o_fin       (fin),
        .i_fin_ready (fin_ready)
    );

    // Scale: multiply by the power of ten for the missing fraction digits
    dttf_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (fin_valid),
        .i_fin       (fin),
        .o_fin_ready (fin_ready),
        .o_out       (o_out)
    );

endmodule

FILE: rtl/core/dttf_parse.sv
// Character parser: digit accumulation, counters, error tracking and end-of-string hand-off.
module dttf_parse import dttf_pkg::*; #(
    parameter logic [CNT_W-1:0] INTEGER_DIGITS  = INT_DIGITS,
    parameter logic [CNT_W-1:0] FRACTION_DIGITS = FRAC_DIGITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_char i_item,
    output logic  o_take,
    output logic  o_fin_valid,
    output t_fin  o_fin,
    input  logic  i_fin_ready
);

    logic [AMOUNT_W-1:0] r_acc, n_acc;
    logic                r_point, n_point;
    logic [CNT_W-1:0]    r_int, n_int;
    logic [CNT_W-1:0]    r_frac, n_frac;
    t_err                r_err, n_err;
    logic                r_fin_valid, n_fin_valid;
    t_fin                r_fin, n_fin;
    logic [AMOUNT_W-1:0] acc_next;
    logic                fin_free;
    t_err                fin_err;

    // acc * 10 + digit as two shifts and two adds
    assign acc_next = {r_acc[AMOUNT_W-4:0], 3'b000} + {r_acc[AMOUNT_W-2:0], 1'b0}
                      + AMOUNT_W'(i_item.character[3:0]);

    assign fin_free = !r_fin_valid || i_fin_ready;
    assign o_take   = i_valid && (!i_item.last || fin_free);

    always_comb begin
        n_acc   = r_acc;
        n_point = r_point;
        n_int   = r_int;
        n_frac  = r_frac;
        n_err   = r_err;
        if (i_item.has_character && r_err == ERR_NONE) begin
            if (i_item.character == CHAR_POINT) begin
                if (r_point) begin
                    n_err = ERR_SECOND_POINT;
                end else begin
                    n_point = 1'b1;
                end
            end else if (!(i_item.character inside {[CHAR_ZERO:CHAR_NINE]})) begin
                n_err = ERR_BAD_CHAR;
            end else if (r_point) begin
                n_frac = sat_inc(r_frac);
                if (n_frac > FRACTION_DIGITS) begin
                    n_err = ERR_FRAC_DIGITS;
                end else begin
                    n_acc = acc_next;
                end
            end else begin
                n_int = sat_inc(r_int);
                if (n_int > INTEGER_DIGITS) begin
                    n_err = ERR_INT_DIGITS;
                end else begin
                    n_acc = acc_next;
                end
            end
        end
    end

    always_comb begin
        if (n_err == ERR_NONE && n_int == '0 && n_frac == '0) begin
            fin_err = ERR_NO_DIGITS;
        end else begin
            fin_err = n_err;
        end
        n_fin.err   = fin_err;
        n_fin.value = (fin_err == ERR_NONE) ? n_acc : '0;
        n_fin.scale = pow10(FRACTION_DIGITS - n_frac);
        n_fin_valid = (r_fin_valid && !i_fin_ready) || (o_take && i_item.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_point     <= 1'b0;
            r_int       <= '0;
            r_frac      <= '0;
            r_err       <= ERR_NONE;
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= n_fin_valid;
            if (o_take) begin
                if (i_item.last) begin
                    r_acc   <= '0;
                    r_point <= 1'b0;
                    r_int   <= '0;
                    r_frac  <= '0;
                    r_err   <= ERR_NONE;
                end else begin
                    r_acc   <= n_acc;
                    r_point <= n_point;
                    r_int   <= n_int;
                    r_frac  <= n_frac;
                    r_err   <= n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.last) begin
            r_fin <= n_fin;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_int <= CNT_SAT) && (r_frac <= CNT_SAT))
        else $error("digit counter beyond saturation");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.last) |=>
        (r_acc == '0 && r_int == '0 && r_frac == '0 && !r_point && r_err == ERR_NONE))
        else $error("string state not cleared after end of string");
`endif

endmodule

FILE: rtl/core/dttf_scale.sv
// Scaler: amount times 10^(missing fraction digits) as two half-width products, then output register.
module dttf_scale import dttf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fin_valid,
    input  t_fin i_fin,
    output logic o_fin_ready,
    dttf_out_if.source o_out
);

    logic                      r_prod_valid;
    logic [HALF_W+SCALE_W-1:0] r_lo;
    logic [HALF_W-1:0]         r_hi;
    t_err                      r_prod_err;
    logic [HALF_W+SCALE_W-1:0] n_lo;
    logic [HALF_W+SCALE_W-1:0] n_hi_full;
    logic                      r_out_valid;
    logic [AMOUNT_W-1:0]       r_amount;
    t_err                      r_out_err;
    logic                      out_free;
    logic                      prod_adv;

    assign n_lo      = (HALF_W+SCALE_W)'(i_fin.value[HALF_W-1:0]) * (HALF_W+SCALE_W)'(i_fin.scale);
    assign n_hi_full = (HALF_W+SCALE_W)'(i_fin.value[AMOUNT_W-1:HALF_W])
                       * (HALF_W+SCALE_W)'(i_fin.scale);

    assign out_free    = !r_out_valid || o_out.ready;
    assign prod_adv    = r_prod_valid && out_free;
    assign o_fin_ready = !r_prod_valid || prod_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_fin_ready) begin
                r_prod_valid <= i_fin_valid;
            end
            if (out_free) begin
                r_out_valid <= r_prod_valid;
            end
        end
    end

    // Only the low half of the upper product survives the 2^54 wrap
    always_ff @(posedge i_clk) begin
        if (o_fin_ready && i_fin_valid) begin
            r_lo       <= n_lo;
            r_hi       <= n_hi_full[HALF_W-1:0];
            r_prod_err <= i_fin.err;
        end
        if (prod_adv) begin
            r_amount  <= r_lo[AMOUNT_W-1:0] + {r_hi, {HALF_W{1'b0}}};
            r_out_err <= r_prod_err;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.amount     = r_amount;
    assign o_out.error_code = r_out_err;
    assign o_out.valid_res  = (r_out_err == ERR_NONE);

`ifndef ASSERT_OFF
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err != ERR_NONE) |-> (r_amount == '0))
        else $error("nonzero amount on an error word");

    a_prod_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prod_valid && r_prod_err != ERR_NONE) |-> (r_lo == '0 && r_hi == '0))
        else $error("nonzero partial products on an error word");
`endif

endmodule

FILE: tb/decimal_text_to_fixed_point_core_tb.sv
// Self-checking testbench of the decimal text to fixed point core.
`timescale 1ns / 100ps

module decimal_text_to_fixed_point_core_tb import dttf_pkg::*;;

    localparam int RESET_CYCLES = 8;
    localparam int WORD_TARGET  = 1200;   // character and end-mark words to send
    localparam int STALL_LIMIT  = 2000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 16;     // four-stage pipe, with margin

    typedef logic [CHAR_W-1:0] t_char_seq[$];

    // One expected result word
    typedef struct {
        logic                valid_res;
        logic [AMOUNT_W-1:0] amount;
        t_err                err;
    } t_amount_word;

    // Receiver back-pressure styles
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN,
        RX_CHOKED
    } t_rx_style;

    logic clk = 1'b0;
    logic rst_n;

    dttf_in_if  in_if ();
    dttf_out_if out_if ();

    decimal_text_to_fixed_point_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Parser state mirrored on the testbench side
    logic [AMOUNT_W-1:0] digits_value = '0;
    logic                point_taken  = 1'b0;
    logic [CNT_W-1:0]    int_count    = '0;
    logic [CNT_W-1:0]    frac_count   = '0;
    t_err                first_err    = ERR_NONE;

    t_amount_word pending_amounts[$];

    int mismatches   = 0;
    int text_words   = 0;   // words carrying a character or the end mark
    int ignored_words = 0;  // end-only words without last
    int results_seen = 0;
    int code_seen[8] = '{default: 0};
    int burst_left   = 0;

    // Fold one accepted word into the mirrored state; on last, queue the amount.
    function automatic void fold_text_word(input logic [CHAR_W-1:0] ch, input logic has,
                                           input logic lst);
        t_amount_word res;
        logic         over;
        t_err         over_code;
        int           k;
        if (has && first_err == ERR_NONE) begin
            if (ch == CHAR_POINT) begin
                if (point_taken) begin
                    first_err = ERR_SECOND_POINT;
                end else begin
                    point_taken = 1'b1;
                end
            end else if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
                first_err = ERR_BAD_CHAR;
            end else begin
                // counts saturate; the digit that crosses the limit flags the error
                if (point_taken) begin
                    frac_count = (frac_count >= CNT_SAT) ? CNT_SAT : frac_count + 4'd1;
                    over       = frac_count > FRAC_DIGITS;
                    over_code  = ERR_FRAC_DIGITS;
                end else begin
                    int_count = (int_count >= CNT_SAT) ? CNT_SAT : int_count + 4'd1;
                    over      = int_count > INT_DIGITS;
                    over_code = ERR_INT_DIGITS;
                end
                if (over) begin
                    first_err = over_code;
                end else begin
                    digits_value = digits_value * 10 + (ch - CHAR_ZERO);
                end
            end
        end
        if (lst) begin
            res.err = first_err;
            if (res.err == ERR_NONE && int_count == 0 && frac_count == 0) begin
                res.err = ERR_NO_DIGITS;
            end
            res.valid_res = (res.err == ERR_NONE);
            res.amount    = '0;
            if (res.valid_res) begin
                // pad missing fraction digits up to the fixed scale
                res.amount = digits_value;
                for (k = int'(frac_count); k < int'(FRAC_DIGITS); k++) begin
                    res.amount = res.amount * 10;
                end
            end
            pending_amounts.push_back(res);
            digits_value = '0;
            point_taken  = 1'b0;
            int_count    = '0;
            frac_count   = '0;
            first_err    = ERR_NONE;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Send one word; open a new burst after a random gap when the last one ran out.
    task automatic send_word(input logic [CHAR_W-1:0] ch, input logic has, input logic lst);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 16);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_if.valid         <= 1'b1;
        in_if.character     <= ch;
        in_if.has_character <= has;
        in_if.last          <= lst;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        burst_left--;
        if (has || lst) begin
            text_words++;
        end else begin
            ignored_words++;
        end
        fold_text_word(ch, has, lst);
    endtask

    // Send a string; tail puts the end mark on a word of its own, junk sprinkles
    // ignored end-only words in between.
    task automatic send_chars(input t_char_seq text, input bit tail, input bit junk);
        int i;
        for (i = 0; i < text.size(); i++) begin
            if (junk && $urandom_range(0, 11) == 0) begin
                send_word(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_word(text[i], 1'b1, !tail && i == text.size() - 1);
        end
        if (tail) begin
            send_word(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    function automatic t_char_seq chars_of(input string s);
        t_char_seq q;
        int        i;
        for (i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    function automatic int pick_digit_count();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return 0;
        if (r == 1) return 8;
        return $urandom_range(1, 8);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_digit(input int fill);
        if (fill == 0) return CHAR_NINE;
        if (fill == 1) return CHAR_ZERO;
        return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    // Empty string and a lone point both carry no digits.
    task automatic test_no_digits();
        t_char_seq none;
        send_chars(none, 1'b1, 1'b0);
        send_chars(chars_of("."), 1'b0, 1'b0);
    endtask

    task automatic test_point_at_ends();
        send_chars(chars_of("5."), 1'b0, 1'b0);
        send_chars(chars_of(".5"), 1'b0, 1'b0);
    endtask

    // An end-only word without last must leave the string untouched.
    task automatic test_end_only_words();
        send_word(8'hFF, 1'b0, 1'b0);
        send_chars(chars_of("7"), 1'b0, 1'b0);
    endtask

    task automatic test_bad_text();
        t_char_seq seq;
        seq.push_back(8'hFF);
        send_chars(seq, 1'b0, 1'b0);
        send_chars(chars_of(".."), 1'b0, 1'b0);
        // the sign is found first, so the second point must not override it
        send_chars(chars_of("-.."), 1'b0, 1'b0);
    endtask

    task automatic test_integer_overflow();
        send_chars(chars_of("123456789"), 1'b0, 1'b0);
    endtask

    // Mostly well-formed amounts with random content, the rest overflow and noise.
    task automatic test_random_strings();
        t_char_seq text;
        int        style, int_len, frac_len, fill, len, i, r;
        bit        with_point, tail;
        while (text_words < WORD_TARGET) begin
            text.delete();
            style = $urandom_range(0, 15);
            tail  = ($urandom_range(0, 5) == 0);
            if (style <= 12) begin
                int_len    = pick_digit_count();
                frac_len   = pick_digit_count();
                with_point = (frac_len != 0) || ($urandom_range(0, 3) == 0);
                if (style >= 11) begin
                    if ($urandom_range(0, 1) == 1) begin
                        int_len = $urandom_range(9, 11);
                    end else begin
                        frac_len   = $urandom_range(9, 11);
                        with_point = 1'b1;
                    end
                end
                fill = $urandom_range(0, 5);
                for (i = 0; i < int_len; i++) text.push_back(pick_digit(fill));
                if (with_point) text.push_back(CHAR_POINT);
                for (i = 0; i < frac_len; i++) text.push_back(pick_digit(fill));
            end else begin
                len = $urandom_range(1, 10);
                for (i = 0; i < len; i++) begin
                    r = $urandom_range(0, 3);
                    if (r == 0) begin
                        text.push_back(CHAR_W'($urandom_range(0, 255)));
                    end else if (r == 1) begin
                        text.push_back(CHAR_POINT);
                    end else begin
                        text.push_back(pick_digit(2));
                    end
                end
            end
            if (text.size() == 0) tail = 1'b1;
            send_chars(text, tail, 1'b1);
        end
    endtask

    // Result checker; also drives the receiver's stall pattern.
    initial begin : amount_checker
        t_amount_word want;
        t_rx_style    rx_style;
        int           cycle_count;
        cycle_count  = 0;
        rx_style     = RX_OPEN;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                results_seen++;
                if (pending_amounts.size() == 0) begin
                    report_mismatch("result with nothing expected, error_code",
                                    out_if.error_code, 0);
                end else begin
                    want = pending_amounts.pop_front();
                    code_seen[want.err]++;
                    if (out_if.valid_res !== want.valid_res) begin
                        report_mismatch("valid_res", out_if.valid_res, want.valid_res);
                    end
                    if (out_if.amount !== want.amount) begin
                        report_mismatch("amount", out_if.amount, want.amount);
                    end
                    if (out_if.error_code !== want.err) begin
                        report_mismatch("error_code", out_if.error_code, want.err);
                    end
                end
            end
            // switch style on the cycle counter so stalls land on every pipe phase
            if (cycle_count % 96 == 0) rx_style = t_rx_style'($urandom_range(0, 3));
            cycle_count++;
            if (rst_n !== 1'b1) begin
                out_if.ready <= 1'b0;
            end else begin
                case (rx_style)
                    RX_OPEN:    out_if.ready <= 1'b1;
                    RX_RANDOM:  out_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: out_if.ready <= ((cycle_count / 3) % 2 == 0);
                    default:    out_if.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Watchdog: drop out if nothing moves for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, pending_amounts.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        rst_n               <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.character     <= '0;
        in_if.has_character <= 1'b0;
        in_if.last          <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_no_digits();
        test_point_at_ends();
        test_end_only_words();
        test_bad_text();
        test_integer_overflow();
        test_random_strings();

        in_if.valid <= 1'b0;
        while (pending_amounts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d text words and %0d ignored end-only words, %0d results",
                 text_words, ignored_words, results_seen);
        $display("by code: ok %0d, bad char %0d, second point %0d, int %0d, frac %0d, none %0d",
                 code_seen[ERR_NONE], code_seen[ERR_BAD_CHAR], code_seen[ERR_SECOND_POINT],
                 code_seen[ERR_INT_DIGITS], code_seen[ERR_FRAC_DIGITS],
                 code_seen[ERR_NO_DIGITS]);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
